// File: rtl/core/linear_blend_skinning_top_macros.svh
// Assertion macros for the linear blend skinning engine.
// Needs a clk and rst_n in scope where used; no other dependencies.
`ifndef LINEAR_BLEND_SKINNING_TOP_MACROS_SVH
`define LINEAR_BLEND_SKINNING_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbs assertion failed");

// Next-cycle implication, checked outside reset.
`define LBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbs assertion failed");

`endif

// File: rtl/core/lbs_pkg.sv
// Package for the linear blend skinning engine: sizes, codes and item types.
// No dependencies; used by lbs_palette and linear_blend_skinning_top.
`default_nettype none

package lbs_pkg;

    localparam int BONE_COUNT    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int WEIGHT_BITS   = 16;
    localparam int BONE_AW       = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam int LANES         = 4;
    localparam int ROWS          = 3;
    localparam int COLS          = 3;
    localparam int ELEMS         = 12;

    // Widths of the datapath
    localparam int PROD_W = 64;   // matrix entry times coordinate
    localparam int SUM_W  = 66;   // sum of three products plus translation
    localparam int PART_W = 46;   // per-bone component after clamp to +-2^44
    localparam int WACC_W = 66;   // sum of four weighted components

    localparam logic [6:0] BONE_LIMIT  = 7'(BONE_COUNT);
    localparam logic [5:0] UNUSED_BONE = 6'h3F;
    localparam logic [3:0] ELEM_LIMIT  = 4'(ELEMS);

    localparam logic signed [SUM_W-1:0] PART_HI = 66'sd17592186044416;
    localparam logic signed [SUM_W-1:0] PART_LO = -66'sd17592186044416;
    localparam logic signed [WACC_W-1:0] OUT_HI = 66'sd2147483647;
    localparam logic signed [WACC_W-1:0] OUT_LO = -66'sd2147483648;

    typedef enum logic {
        OP_PALETTE_WRITE = 1'b0,
        OP_SKIN          = 1'b1
    } op_t;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        op_t                operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [23:0]        bone_set;
        logic [16:0]        weight_a;
        logic [16:0]        weight_b;
        logic [16:0]        weight_c;
        logic [16:0]        weight_d;
        logic [4:0]         palette_slot;
        logic [3:0]         palette_element;
        logic signed [31:0] palette_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] skinned_z;
        logic               saturated_flag;
    } out_item_t;

    typedef struct packed {
        logic               en;
        logic [BONE_AW-1:0] addr;
        logic [3:0]         elem;
        word_t              data;
    } pal_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/lbs_palette.sv
// Bone palette: one copy per bone lane, one bank per matrix entry, so a lane
// reads a full 3x4 matrix per cycle while rd_en is high. Depends on lbs_pkg.
`default_nettype none

module lbs_palette (
    input  wire logic                                   clk,
    input  wire lbs_pkg::pal_wr_t                       wr,
    input  wire logic                                   rd_en,
    input  wire logic [lbs_pkg::LANES-1:0][lbs_pkg::BONE_AW-1:0] rd_addr,
    output lbs_pkg::word_t rd_data [lbs_pkg::LANES][lbs_pkg::ELEMS]
);

    for (genvar l = 0; l < lbs_pkg::LANES; l++) begin : g_lane
        for (genvar e = 0; e < lbs_pkg::ELEMS; e++) begin : g_elem
            lbs_pkg::word_t mem [lbs_pkg::BONE_COUNT];
            lbs_pkg::word_t rd_reg;

            // write every copy, read only this lane's bone
            always_ff @(posedge clk)
            begin
                if (wr.en && (wr.elem == 4'(e)))
                begin
                    mem[wr.addr] <= wr.data;
                end
                if (rd_en)
                begin
                    rd_reg <= mem[rd_addr[l]];
                end
            end

            assign rd_data[l][e] = rd_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/linear_blend_skinning_top.sv
// Top level of the four-bone linear blend skinning engine.
// Depends on lbs_pkg, lbs_palette and linear_blend_skinning_top_macros.svh.
`default_nettype none
`include "linear_blend_skinning_top_macros.svh"

// Takes one item per cycle while in_ready is high. A palette-write item stores
// one matrix entry and gives no result. A skin item passes five register stages
// (palette read, products, per-bone sum and clamp, weighting, final sum and
// clamp into the output register), and its result is then presented.
// Stages hold independently, so bubbles are absorbed and input is still taken
// while a finished result waits. A skin item sees every palette write accepted
// before it. The palette has no reset: reading a never-written entry returns
// undefined data.
module linear_blend_skinning_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lbs_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lbs_pkg::out_item_t     out_item
);

    localparam int L = lbs_pkg::LANES;
    localparam int R = lbs_pkg::ROWS;
    localparam int C = lbs_pkg::COLS;

    // Stage enables: a stage loads when empty or when the next one loads
    logic out_en, s4_en, s3_en, s2_en, s1_en;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;

    assign out_en   = !out_valid_reg || out_ready;
    assign s4_en    = !s4_valid_reg || out_en;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    logic in_take, skin_take;
    assign in_take   = in_valid && in_ready;
    assign skin_take = in_take && (in_item.operation == lbs_pkg::OP_SKIN);

    // Palette write decode: drop writes beyond the slot count or element 11
    lbs_pkg::pal_wr_t pal_wr;
    logic [5:0]       slot_ext;
    assign slot_ext     = {1'b0, in_item.palette_slot};
    assign pal_wr.en    = in_take && (in_item.operation == lbs_pkg::OP_PALETTE_WRITE)
                          && ({1'b0, slot_ext} < lbs_pkg::BONE_LIMIT)
                          && (in_item.palette_element < lbs_pkg::ELEM_LIMIT);
    assign pal_wr.addr  = slot_ext[lbs_pkg::BONE_AW-1:0];
    assign pal_wr.elem  = in_item.palette_element;
    assign pal_wr.data  = in_item.palette_value;

    // Bone lane decode
    logic [L-1:0][5:0]                  bone_idx;
    logic [L-1:0][lbs_pkg::BONE_AW-1:0] rd_addr;
    logic [L-1:0]                       used_next;
    logic [L-1:0][16:0]                 w_next;

    assign w_next = {in_item.weight_d, in_item.weight_c, in_item.weight_b, in_item.weight_a};

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            bone_idx[l]  = in_item.bone_set[6*l +: 6];
            rd_addr[l]   = bone_idx[l][lbs_pkg::BONE_AW-1:0];
            used_next[l] = (bone_idx[l] != lbs_pkg::UNUSED_BONE)
                           && ({1'b0, bone_idx[l]} < lbs_pkg::BONE_LIMIT);
        end
    end

    lbs_pkg::word_t rd_data [L][lbs_pkg::ELEMS];

    lbs_palette u_palette (
        .clk     (clk),
        .wr      (pal_wr),
        .rd_en   (s1_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------- stage 1: palette read, position and weights
    lbs_pkg::word_t     s1_pos_reg [C];
    logic [L-1:0][16:0] s1_w_reg;
    logic [L-1:0]       s1_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= skin_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_pos_reg[0] <= in_item.pos_x;
            s1_pos_reg[1] <= in_item.pos_y;
            s1_pos_reg[2] <= in_item.pos_z;
            s1_w_reg      <= w_next;
            s1_used_reg   <= used_next;
        end
    end

    // ---------------- stage 2: one multiplier per 3x3 matrix entry, times its coordinate
    logic signed [lbs_pkg::PROD_W-1:0] s2_prod_reg [L][R][C];
    lbs_pkg::word_t                    s2_m3_reg [L][R];
    logic [L-1:0][16:0]                s2_w_reg;
    logic [L-1:0]                      s2_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            for (int l = 0; l < L; l++)
            begin
                for (int r = 0; r < R; r++)
                begin
                    for (int c = 0; c < C; c++)
                    begin
                        s2_prod_reg[l][r][c] <= lbs_pkg::PROD_W'(rd_data[l][4*r+c])
                                                * lbs_pkg::PROD_W'(s1_pos_reg[c]);
                    end
                    s2_m3_reg[l][r] <= rd_data[l][4*r+3];
                end
            end
            s2_w_reg    <= s1_w_reg;
            s2_used_reg <= s1_used_reg;
        end
    end

    // ---------------- stage 3: per-bone component, floor, translate, clamp
    logic signed [lbs_pkg::SUM_W-1:0]  part_sum [L][R];
    logic signed [lbs_pkg::PART_W-1:0] part_next [L][R];
    logic [L-1:0][R-1:0]               part_clip;

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            for (int r = 0; r < R; r++)
            begin
                part_sum[l][r] = ((lbs_pkg::SUM_W'(s2_prod_reg[l][r][0])
                                  + lbs_pkg::SUM_W'(s2_prod_reg[l][r][1])
                                  + lbs_pkg::SUM_W'(s2_prod_reg[l][r][2]))
                                  >>> lbs_pkg::FRACTION_BITS)
                                 + lbs_pkg::SUM_W'(s2_m3_reg[l][r]);
                part_clip[l][r] = 1'b0;
                if (!s2_used_reg[l])
                begin
                    part_next[l][r] = '0;
                end
                else if (part_sum[l][r] > lbs_pkg::PART_HI)
                begin
                    part_next[l][r] = lbs_pkg::PART_HI[lbs_pkg::PART_W-1:0];
                    part_clip[l][r] = 1'b1;
                end
                else if (part_sum[l][r] < lbs_pkg::PART_LO)
                begin
                    part_next[l][r] = lbs_pkg::PART_LO[lbs_pkg::PART_W-1:0];
                    part_clip[l][r] = 1'b1;
                end
                else
                begin
                    part_next[l][r] = part_sum[l][r][lbs_pkg::PART_W-1:0];
                end
            end
        end
    end

    logic signed [lbs_pkg::PART_W-1:0] s3_part_reg [L][R];
    logic [L-1:0][16:0]                s3_w_reg;
    logic                              s3_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            s3_part_reg <= part_next;
            s3_w_reg    <= s2_w_reg;
            s3_clip_reg <= |part_clip;
        end
    end

    // ---------------- stage 4: weight each component
    logic signed [lbs_pkg::PROD_W-1:0] s4_wp_reg [L][R];
    logic                              s4_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_en)
        begin
            for (int l = 0; l < L; l++)
            begin
                for (int r = 0; r < R; r++)
                begin
                    s4_wp_reg[l][r] <= lbs_pkg::PROD_W'(s3_part_reg[l][r])
                                       * lbs_pkg::PROD_W'($signed({1'b0, s3_w_reg[l]}));
                end
            end
            s4_clip_reg <= s3_clip_reg;
        end
    end

    // ---------------- output stage: blend, floor by the weight scale, saturate
    logic signed [lbs_pkg::WACC_W-1:0] blend [R];
    lbs_pkg::word_t                    comp_next [R];
    logic [R-1:0]                      comp_clip;

    always_comb
    begin
        for (int r = 0; r < R; r++)
        begin
            blend[r] = (lbs_pkg::WACC_W'(s4_wp_reg[0][r]) + lbs_pkg::WACC_W'(s4_wp_reg[1][r])
                        + lbs_pkg::WACC_W'(s4_wp_reg[2][r]) + lbs_pkg::WACC_W'(s4_wp_reg[3][r]))
                       >>> lbs_pkg::WEIGHT_BITS;
            comp_clip[r] = 1'b0;
            if (blend[r] > lbs_pkg::OUT_HI)
            begin
                comp_next[r] = lbs_pkg::OUT_HI[31:0];
                comp_clip[r] = 1'b1;
            end
            else if (blend[r] < lbs_pkg::OUT_LO)
            begin
                comp_next[r] = lbs_pkg::OUT_LO[31:0];
                comp_clip[r] = 1'b1;
            end
            else
            begin
                comp_next[r] = blend[r][31:0];
            end
        end
    end

    lbs_pkg::out_item_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_item_reg.skinned_x      <= comp_next[0];
            out_item_reg.skinned_y      <= comp_next[1];
            out_item_reg.skinned_z      <= comp_next[2];
            out_item_reg.saturated_flag <= s4_clip_reg || (|comp_clip);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---------------- checks
    // a palette write never enters the pipeline, a skin item always does
    `LBS_ASSERT_NEXT(a_write_no_result,
        in_take && (in_item.operation == lbs_pkg::OP_PALETTE_WRITE), !s1_valid_reg)
    `LBS_ASSERT_NEXT(a_skin_enters, skin_take, s1_valid_reg)
    // a held stage keeps its item
    `LBS_ASSERT_NEXT(a_s4_holds, s4_valid_reg && !s4_en, s4_valid_reg)
    // input is never refused while the first stage is empty
    `LBS_ASSERT_NOW(a_ready_when_empty, !s1_valid_reg, in_ready)

endmodule

`default_nettype wire
